### hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

  // Action codes carried in the input word
  localparam logic [2:0] ACT_PUT   = 3'd0;
  localparam logic [2:0] ACT_SET   = 3'd1;
  localparam logic [2:0] ACT_CLEAR = 3'd2;
  localparam logic [2:0] ACT_READ  = 3'd3;
  localparam logic [2:0] ACT_AT    = 3'd4;

  // Character codes with special meaning
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Attribute used by the power-on clearing pass
  localparam logic [7:0] ATTR_RESET = 8'd7;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] character;
    logic [6:0] column;
    logic [4:0] row;
  } in_word_t;

  typedef struct packed {
    logic [6:0] cursor_x;
    logic [4:0] cursor_y;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_TABDIV,
    ST_TABAPP,
    ST_SCROLL,
    ST_BLANK,
    ST_RESP
  } st_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_CHAR,
    CUR_NL,
    CUR_TAB,
    CUR_SET,
    CUR_ZERO,
    CUR_BOTTOM
  } cur_op_e;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_PUT,
    MEM_AT,
    MEM_READ,
    MEM_FILL,
    MEM_SHIFT
  } mem_op_e;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC
  } ptr_op_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    in_load;
    cur_op_e cur_op;
    mem_op_e mem_op;
    ptr_op_e ptr_op;
    logic    fill_init;
    logic    rem_start;
    logic    rem_step;
    logic    scr_set;
    logic    out_load;
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [2:0] action;
    logic       is_nl;
    logic       is_tab;
    logic       wrap;
    logic       ptr_bottom;
    logic       ptr_last;
  } dp_sts_t;

endpackage

### hw/rtl/tcw_stream_if.sv
// Valid/ready channel carrying one word of a given type.
interface tcw_stream_if #(
  parameter type word_t = logic [7:0]
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/tcw_ctrl.sv
// Sequencing state machine of the text console writer.
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_sts_t  sts_i,
  output ctl_cmd_t cmd_o
);

  st_e      st_q, st_d;
  logic     out_valid_q, out_valid_d;
  ctl_cmd_t cmd;
  logic     out_busy;

  assign out_busy = out_valid_q && !out_ready_i;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    st_d           = st_q;
    in_ready_o     = 1'b0;
    cmd            = '0;
    cmd.cur_op     = CUR_HOLD;
    cmd.mem_op     = MEM_NONE;
    cmd.ptr_op     = PTR_HOLD;
    case (st_q)
      ST_INIT: begin
        cmd.mem_op    = MEM_FILL;
        cmd.fill_init = 1'b1;
        cmd.ptr_op    = PTR_INC;
        if (sts_i.ptr_last) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.in_load = 1'b1;
          st_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.action)
          ACT_PUT: begin
            if (sts_i.is_tab) begin
              cmd.rem_start = 1'b1;
              st_d          = ST_TABDIV;
            end else begin
              if (!sts_i.is_nl) begin
                cmd.mem_op = MEM_PUT;
              end
              if (sts_i.wrap) begin
                cmd.cur_op  = CUR_BOTTOM;
                cmd.scr_set = 1'b1;
                cmd.ptr_op  = PTR_ZERO;
                st_d        = ST_SCROLL;
              end else begin
                cmd.cur_op = sts_i.is_nl ? CUR_NL : CUR_CHAR;
                st_d       = ST_RESP;
              end
            end
          end
          ACT_SET: begin
            cmd.cur_op = CUR_SET;
            st_d       = ST_RESP;
          end
          ACT_CLEAR: begin
            cmd.cur_op = CUR_ZERO;
            cmd.ptr_op = PTR_ZERO;
            st_d       = ST_BLANK;
          end
          ACT_READ: begin
            cmd.mem_op = MEM_READ;
            st_d       = ST_RESP;
          end
          ACT_AT: begin
            cmd.mem_op = MEM_AT;
            st_d       = ST_RESP;
          end
          default: begin
            st_d = ST_RESP;
          end
        endcase
      end
      ST_TABDIV: begin
        cmd.rem_step = 1'b1;
        st_d         = ST_TABAPP;
      end
      ST_TABAPP: begin
        if (sts_i.wrap) begin
          cmd.cur_op  = CUR_BOTTOM;
          cmd.scr_set = 1'b1;
          cmd.ptr_op  = PTR_ZERO;
          st_d        = ST_SCROLL;
        end else begin
          cmd.cur_op = CUR_TAB;
          st_d       = ST_RESP;
        end
      end
      ST_SCROLL: begin
        // pointer stays on the first bottom-row cell so blanking starts there
        cmd.mem_op = MEM_SHIFT;
        if (sts_i.ptr_bottom) begin
          st_d = ST_BLANK;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      ST_BLANK: begin
        cmd.mem_op = MEM_FILL;
        cmd.ptr_op = PTR_INC;
        if (sts_i.ptr_last) begin
          st_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          st_d         = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Output word valid: held until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // Checks
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> st_q == ST_EXEC)
    else $error("accepted word did not enter execution");

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !out_busy)
    else $error("result loaded over a waiting word");

  a_init_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_INIT |-> !out_valid_q && !in_ready_o)
    else $error("traffic during clearing pass");

endmodule

### hw/rtl/tcw_dp.sv
// Datapath: screen memory, cursor, remainder unit and result register.
module tcw_dp
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctl_cmd_t  cmd_i,
  output dp_sts_t   sts_o,
  input  in_word_t  in_word_i,
  input  logic      cfg_valid_i,
  input  logic [7:0] cfg_data_i,
  output out_word_t out_word_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int LAST  = (ROWS - 1) * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int LW    = $clog2(CELLS + TAB_STOP);
  localparam int XW    = $clog2(COLUMNS);
  localparam int YW    = $clog2(ROWS);
  localparam int XDW   = $clog2(COLUMNS + TAB_STOP);
  localparam int TW    = $clog2(TAB_STOP + 1);
  // reciprocal of the tab stop, exact for every cursor value
  localparam int RS    = AW + TW;
  localparam int RM    = (2 ** RS + TAB_STOP - 1) / TAB_STOP;
  localparam int PW    = AW + RS + 1;

  in_word_t        in_q;
  logic [7:0]      attr_q;
  logic [XW-1:0]   x_q, x_d;
  logic [YW-1:0]   y_q, y_d;
  logic [AW-1:0]   lin_q, lin_d;
  logic [AW-1:0]   ptr_q;
  logic [AW-1:0]   rem_q;
  logic [AW-1:0]   quo_q;
  logic            scr_q;
  logic [15:0]     mem_q [CELLS];
  logic [15:0]     rdata_q;
  out_word_t       out_q;

  logic [XW-1:0]   cx;
  logic [YW-1:0]   cy;
  logic [AW-1:0]   addr;
  logic [TW-1:0]   tab_d;
  logic [XDW-1:0]  xs0, xs1, xs2;
  logic            yi1, yi2;
  logic [LW-1:0]   lin_tab;
  logic            wrap_tab;
  logic [PW-1:0]   quo_prod;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [15:0]     mem_wdata;

  // Clamped coordinates and their cell address
  always_comb begin
    cx   = ({2'b00, in_q.column} > 9'(COLUMNS - 1)) ? XW'(COLUMNS - 1) : XW'(in_q.column);
    cy   = ({3'b000, in_q.row} > 8'(ROWS - 1)) ? YW'(ROWS - 1) : YW'(in_q.row);
    addr = AW'(cy * COLUMNS) + AW'(cx);
  end

  // Tab target: distance to the next stop, at most two row wraps
  always_comb begin
    tab_d    = TW'(TAB_STOP) - TW'(rem_q);
    xs0      = XDW'(x_q) + XDW'(tab_d);
    yi1      = xs0 >= XDW'(COLUMNS);
    xs1      = yi1 ? xs0 - XDW'(COLUMNS) : xs0;
    yi2      = xs1 >= XDW'(COLUMNS);
    xs2      = yi2 ? xs1 - XDW'(COLUMNS) : xs1;
    lin_tab  = LW'(lin_q) + LW'(tab_d);
    wrap_tab = lin_tab >= LW'(CELLS);
  end

  // Cursor next value
  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    lin_d = lin_q;
    case (cmd_i.cur_op)
      CUR_CHAR: begin
        lin_d = lin_q + AW'(1);
        if (x_q == XW'(COLUMNS - 1)) begin
          x_d = '0;
          y_d = y_q + YW'(1);
        end else begin
          x_d = x_q + XW'(1);
        end
      end
      CUR_NL: begin
        lin_d = AW'(LW'(lin_q) + LW'(COLUMNS) - LW'(x_q));
        x_d   = '0;
        y_d   = y_q + YW'(1);
      end
      CUR_TAB: begin
        lin_d = AW'(lin_tab);
        x_d   = XW'(xs2);
        y_d   = y_q + YW'(yi1) + YW'(yi2);
      end
      CUR_SET: begin
        lin_d = addr;
        x_d   = cx;
        y_d   = cy;
      end
      CUR_ZERO: begin
        lin_d = '0;
        x_d   = '0;
        y_d   = '0;
      end
      CUR_BOTTOM: begin
        lin_d = AW'(LAST);
        x_d   = '0;
        y_d   = YW'(ROWS - 1);
      end
      default: begin
        lin_d = lin_q;
      end
    endcase
  end

  // Cursor, attribute, sweep pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      lin_q  <= '0;
      ptr_q  <= '0;
      attr_q <= ATTR_RESET;
    end else begin
      x_q   <= x_d;
      y_q   <= y_d;
      lin_q <= lin_d;
      if (cfg_valid_i) begin
        attr_q <= cfg_data_i;
      end
      case (cmd_i.ptr_op)
        PTR_ZERO: ptr_q <= '0;
        PTR_INC:  ptr_q <= ptr_q + AW'(1);
        default:  ptr_q <= ptr_q;
      endcase
    end
  end

  // Remainder of the cursor by the tab stop: quotient by reciprocal
  // multiply, then multiply back and subtract on the next cycle
  always_comb begin
    quo_prod = PW'(lin_q) * PW'(RM);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rem_start) begin
      quo_q <= AW'(quo_prod >> RS);
    end else if (cmd_i.rem_step) begin
      rem_q <= lin_q - AW'(quo_q * TAB_STOP);
    end
  end

  // Input word and scroll flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      in_q  <= in_word_i;
      scr_q <= 1'b0;
    end else if (cmd_i.scr_set) begin
      scr_q <= 1'b1;
    end
  end

  // Screen memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ptr_q;
    mem_raddr = addr;
    mem_wdata = {in_q.character, attr_q};
    case (cmd_i.mem_op)
      MEM_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = lin_q;
      end
      MEM_AT: begin
        mem_we    = 1'b1;
        mem_waddr = addr;
      end
      MEM_READ: begin
        mem_re = 1'b1;
      end
      MEM_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {CH_SPACE, cmd_i.fill_init ? ATTR_RESET : attr_q};
      end
      MEM_SHIFT: begin
        // read one row below, write back what was read last cycle
        mem_re    = ptr_q != AW'(LAST);
        mem_raddr = ptr_q + AW'(COLUMNS);
        mem_we    = ptr_q != '0;
        mem_waddr = ptr_q - AW'(1);
        mem_wdata = rdata_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.cursor_x  <= 7'(x_q);
      out_q.cursor_y  <= 5'(y_q);
      out_q.cell_char <= (in_q.action == ACT_READ) ? rdata_q[15:8] : 8'd0;
      out_q.cell_attr <= (in_q.action == ACT_READ) ? rdata_q[7:0] : 8'd0;
      out_q.scrolled  <= scr_q;
    end
  end

  assign out_word_o = out_q;

  // Status
  always_comb begin
    sts_o.action     = in_q.action;
    sts_o.is_nl      = in_q.character == CH_NL;
    sts_o.is_tab     = in_q.character == CH_TAB;
    sts_o.ptr_bottom = ptr_q == AW'(LAST);
    sts_o.ptr_last   = ptr_q == AW'(CELLS - 1);
    if (in_q.character == CH_NL) begin
      sts_o.wrap = y_q == YW'(ROWS - 1);
    end else if (in_q.character == CH_TAB) begin
      sts_o.wrap = wrap_tab;
    end else begin
      sts_o.wrap = lin_q == AW'(CELLS - 1);
    end
  end

  // Checks
  a_lin_matches_xy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(lin_q) == int'(y_q) * COLUMNS + int'(x_q))
    else $error("linear cursor out of step with column and row");

  a_cursor_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(x_q) < COLUMNS && int'(y_q) < ROWS)
    else $error("cursor outside the screen");

  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cur_op == CUR_TAB |-> int'(rem_q) < TAB_STOP)
    else $error("tab applied before remainder was reduced");

endmodule

### hw/rtl/text_console_writer.sv
// Top level of the text console writer: channels, controller and datapath.
//
// Usage: in_if carries one command word (action, character, column, row);
// out_if returns exactly one result word (cursor_x, cursor_y, cell_char,
// cell_attr, scrolled) per command, in order. cfg_if writes the text
// attribute and is always ready; write it only while no command is pending.
// Each command is accepted in the idle state, executed, and its result is
// placed in an output register; the next command may be accepted while that
// result waits. A short command passes from the execute state to the response
// state, which registers its result word. Path of each command:
//   put character, set cursor, read cell, write at, unused codes: execute, response
//   tab: the remainder by the tab stop is formed as a quotient, then a remainder
//   clear screen: every cell is blanked, one cell per cycle
//   any put that scrolls: rows are copied up, one cell moved per cycle,
//   then the bottom row is blanked.
// After reset the screen memory is swept to spaces with attribute 7, one
// cell per cycle; in_if is not ready meanwhile.
// If the receiver stalls, the result holds in the output register and one
// further command can complete its work before the block waits.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcw_stream_if.sink   in_if,
  tcw_stream_if.source out_if,
  tcw_stream_if.sink   cfg_if
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Attribute writes are taken at any time
  assign cfg_if.ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcw_dp #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_if.data),
    .cfg_valid_i (cfg_if.valid),
    .cfg_data_i  (cfg_if.data),
    .out_word_o  (out_if.data)
  );

endmodule

### dv/text_console_writer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the text console writer: directed table, then random traffic.
module text_console_writer_tb
  import tcw_pkg::*;
;

  localparam int COLS_N = 80;
  localparam int ROWS_N = 25;
  localparam int TAB_W = 8;
  localparam int CELLS = COLS_N * ROWS_N;
  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int PHASE_WORDS = 235;

  // One row of the directed table; want is used only when typed is set
  typedef struct packed {
    in_word_t  cmd;
    logic      typed;
    out_word_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  tcw_stream_if #(.word_t(in_word_t))   cmd_ch ();
  tcw_stream_if #(.word_t(out_word_t))  res_ch ();
  tcw_stream_if #(.word_t(logic [7:0])) attr_ch ();

  text_console_writer #(
    .COLUMNS (COLS_N),
    .ROWS    (ROWS_N),
    .TAB_STOP(TAB_W)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (cmd_ch),
    .out_if(res_ch),
    .cfg_if(attr_ch)
  );

  // Shadow copy of the screen, cursor and attribute register
  logic [7:0] shadow_char [CELLS];
  logic [7:0] shadow_attr [CELLS];
  int         shadow_cursor;
  logic [7:0] text_attr;

  out_word_t pending_results [$];
  int        err_cnt;
  int        cycle_cnt;
  int        src_idle_pct;
  int        sink_idle_pct;
  int        stall_left;

  dir_row_t dir_tab [26] = '{
    '{'{ACT_READ,  8'd0,   7'd0,   5'd0},  1'b1, '{7'd0,  5'd0,  8'd32,  8'd7, 1'b0}},
    '{'{ACT_PUT,   8'd65,  7'd0,   5'd0},  1'b1, '{7'd1,  5'd0,  8'd0,   8'd0, 1'b0}},
    '{'{ACT_READ,  8'd0,   7'd0,   5'd0},  1'b1, '{7'd1,  5'd0,  8'd65,  8'd7, 1'b0}},
    '{'{ACT_PUT,   CH_NL,  7'd0,   5'd0},  1'b1, '{7'd0,  5'd1,  8'd0,   8'd0, 1'b0}},
    '{'{ACT_PUT,   CH_TAB, 7'd0,   5'd0},  1'b1, '{7'd8,  5'd1,  8'd0,   8'd0, 1'b0}},
    '{'{ACT_PUT,   CH_TAB, 7'd0,   5'd0},  1'b1, '{7'd16, 5'd1,  8'd0,   8'd0, 1'b0}},
    '{'{ACT_SET,   8'd0,   7'd127, 5'd31}, 1'b1, '{7'd79, 5'd24, 8'd0,   8'd0, 1'b0}},
    '{'{ACT_READ,  8'd0,   7'd127, 5'd31}, 1'b1, '{7'd79, 5'd24, 8'd32,  8'd7, 1'b0}},
    '{'{ACT_AT,    8'd0,   7'd5,   5'd3},  1'b1, '{7'd79, 5'd24, 8'd0,   8'd0, 1'b0}},
    '{'{ACT_READ,  8'd0,   7'd5,   5'd3},  1'b1, '{7'd79, 5'd24, 8'd0,   8'd7, 1'b0}},
    '{'{3'd5,      8'd0,   7'd0,   5'd0},  1'b1, '{7'd79, 5'd24, 8'd0,   8'd0, 1'b0}},
    '{'{3'd6,      8'd255, 7'd127, 5'd31}, 1'b1, '{7'd79, 5'd24, 8'd0,   8'd0, 1'b0}},
    '{'{3'd7,      8'd0,   7'd0,   5'd0},  1'b1, '{7'd79, 5'd24, 8'd0,   8'd0, 1'b0}},
    '{'{ACT_PUT,   8'd255, 7'd0,   5'd0},  1'b1, '{7'd0,  5'd24, 8'd0,   8'd0, 1'b1}},
    '{'{ACT_READ,  8'd0,   7'd79,  5'd23}, 1'b1, '{7'd0,  5'd24, 8'd255, 8'd7, 1'b0}},
    '{'{ACT_READ,  8'd0,   7'd5,   5'd2},  1'b1, '{7'd0,  5'd24, 8'd0,   8'd7, 1'b0}},
    '{'{ACT_AT,    8'h7e,  7'd90,  5'd10}, 1'b0, '0},
    '{'{ACT_READ,  8'd0,   7'd79,  5'd10}, 1'b0, '0},
    '{'{ACT_SET,   8'd0,   7'd72,  5'd24}, 1'b1, '{7'd72, 5'd24, 8'd0,   8'd0, 1'b0}},
    '{'{ACT_PUT,   CH_TAB, 7'd0,   5'd0},  1'b1, '{7'd0,  5'd24, 8'd0,   8'd0, 1'b1}},
    '{'{ACT_PUT,   CH_NL,  7'd0,   5'd0},  1'b1, '{7'd0,  5'd24, 8'd0,   8'd0, 1'b1}},
    '{'{ACT_PUT,   8'd120, 7'd3,   5'd7},  1'b0, '0},
    '{'{ACT_CLEAR, 8'd0,   7'd0,   5'd0},  1'b1, '{7'd0,  5'd0,  8'd0,   8'd0, 1'b0}},
    '{'{ACT_READ,  8'd0,   7'd79,  5'd24}, 1'b1, '{7'd0,  5'd0,  8'd32,  8'd7, 1'b0}},
    '{'{ACT_PUT,   8'd0,   7'd0,   5'd0},  1'b1, '{7'd1,  5'd0,  8'd0,   8'd0, 1'b0}},
    '{'{ACT_READ,  8'd0,   7'd0,   5'd0},  1'b1, '{7'd1,  5'd0,  8'd0,   8'd7, 1'b0}}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("text_console_writer: mismatch");
      $finish;
    end
  end

  // Screen behavior: one command in, one result word out
  function automatic out_word_t console_step(input in_word_t w);
    int x;
    int y;
    int addr;
    out_word_t r;
    x = (w.column > COLS_N - 1) ? COLS_N - 1 : int'(w.column);
    y = (w.row > ROWS_N - 1) ? ROWS_N - 1 : int'(w.row);
    addr = y * COLS_N + x;
    r = '0;
    if (shadow_cursor >= CELLS) shadow_cursor = 0;
    case (w.action)
      ACT_PUT: begin
        if (w.character == CH_NL) begin
          shadow_cursor += COLS_N - shadow_cursor % COLS_N;
        end else if (w.character == CH_TAB) begin
          shadow_cursor += TAB_W - shadow_cursor % TAB_W;
        end else begin
          shadow_char[shadow_cursor] = w.character;
          shadow_attr[shadow_cursor] = text_attr;
          shadow_cursor++;
        end
        // past the last cell: move rows up, blank the bottom row
        if (shadow_cursor >= CELLS) begin
          for (int i = 0; i < CELLS - COLS_N; i++) begin
            shadow_char[i] = shadow_char[i + COLS_N];
            shadow_attr[i] = shadow_attr[i + COLS_N];
          end
          for (int i = CELLS - COLS_N; i < CELLS; i++) begin
            shadow_char[i] = CH_SPACE;
            shadow_attr[i] = text_attr;
          end
          shadow_cursor = CELLS - COLS_N;
          r.scrolled = 1'b1;
        end
      end
      ACT_SET: shadow_cursor = addr;
      ACT_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          shadow_char[i] = CH_SPACE;
          shadow_attr[i] = text_attr;
        end
        shadow_cursor = 0;
      end
      ACT_READ: begin
        r.cell_char = shadow_char[addr];
        r.cell_attr = shadow_attr[addr];
      end
      ACT_AT: begin
        shadow_char[addr] = w.character;
        shadow_attr[addr] = text_attr;
      end
      default: ;
    endcase
    r.cursor_x = 7'(shadow_cursor % COLS_N);
    r.cursor_y = 5'(shadow_cursor / COLS_N);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
  endtask

  function automatic in_word_t make_cmd(input logic [2:0] act, input logic [7:0] ch,
                                        input logic [6:0] col, input logic [4:0] row);
    in_word_t w;
    w.action = act;
    w.character = ch;
    w.column = col;
    w.row = row;
    return w;
  endfunction

  // Random bytes, with an extra share of newlines and tabs
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return CH_NL;
    if (r < 16) return CH_TAB;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one command word; on acceptance record the result it must produce
  task automatic send_cmd(input in_word_t w, input bit typed = 1'b0,
                          input out_word_t want = '0);
    out_word_t pred;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= w;
    do @(posedge clk_i); while (!cmd_ch.ready);
    pred = console_step(w);
    pending_results.push_back(typed ? want : pred);
  endtask

  // Stop offering and wait for every outstanding result word
  task automatic drain();
    @(negedge clk_i);
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_attr(input logic [7:0] a);
    @(negedge clk_i);
    attr_ch.valid <= 1'b1;
    attr_ch.data  <= a;
    do @(posedge clk_i); while (!attr_ch.ready);
    text_attr = a;
    @(negedge clk_i);
    attr_ch.valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int n_words);
    int done;
    int pick;
    int burst;
    logic [2:0] act;
    done = 0;
    while (done < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // line near the bottom right, then a run of text that usually scrolls
        send_cmd(make_cmd(ACT_SET, 8'($urandom_range(0, 255)), 7'($urandom_range(40, 127)),
                          5'($urandom_range(24, 31))));
        burst = $urandom_range(4, 40);
        repeat (burst) begin
          send_cmd(make_cmd(ACT_PUT, pick_text_byte(), 7'($urandom_range(0, 127)),
                            5'($urandom_range(0, 31))));
        end
        done += burst + 1;
      end else begin
        if (pick < 42) act = ACT_PUT;
        else if (pick < 54) act = ACT_SET;
        else if (pick < 68) act = ACT_READ;
        else if (pick < 82) act = ACT_AT;
        else if (pick < 87) act = 3'($urandom_range(5, 7));
        else if (pick < 88) act = ACT_CLEAR;
        else act = ACT_READ;
        send_cmd(make_cmd(act, (act == ACT_PUT) ? pick_text_byte() : 8'($urandom_range(0, 255)),
                          7'($urandom_range(0, 127)), 5'($urandom_range(0, 31))));
        done++;
      end
    end
  endtask

  // Result side: ready with random gaps, or held low for a counted stretch
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    out_word_t want;
    out_word_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with no command outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("cursor_x", int'(got.cursor_x), int'(want.cursor_x));
        check_field("cursor_y", int'(got.cursor_y), int'(want.cursor_y));
        check_field("cell_char", int'(got.cell_char), int'(want.cell_char));
        check_field("cell_attr", int'(got.cell_attr), int'(want.cell_attr));
        check_field("scrolled", int'(got.scrolled), int'(want.scrolled));
      end
    end
  end

  // Main sequence
  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    attr_ch.valid = 1'b0;
    attr_ch.data = '0;
    err_cnt = 0;
    cycle_cnt = 0;
    stall_left = 0;
    src_idle_pct = 22;
    sink_idle_pct = 47;
    for (int i = 0; i < CELLS; i++) begin
      shadow_char[i] = CH_SPACE;
      shadow_attr[i] = ATTR_RESET;
    end
    shadow_cursor = 0;
    text_attr = ATTR_RESET;

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, reset attribute
    foreach (dir_tab[i]) send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].want);
    drain();

    // random phases: attribute extremes first, idling pattern changes every two
    for (int p = 0; p < 6; p++) begin
      if (p == 0) write_attr(8'h00);
      else if (p == 1) write_attr(8'hff);
      else write_attr(8'($urandom_range(0, 255)));
      if (p < 2) begin
        src_idle_pct = 22;
        sink_idle_pct = 47;
      end else if (p < 4) begin
        src_idle_pct = 47;
        sink_idle_pct = 22;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      // long result stall while commands keep coming, to back up the input
      if (p == 1) stall_left = 400;
      run_random_phase(PHASE_WORDS);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("text_console_writer: match");
    end else begin
      $display("text_console_writer: mismatch");
    end
    $finish;
  end

endmodule
